[sv/hac_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table for the harmonic angle compensator.
// Has no dependencies; every other file refers to it by scoped names.
package hac_pkg;

    // Widths of the angle path and of the configuration fields.
    localparam int ANGLE_BITS = 21;
    localparam int PHASE_BITS = 16;
    localparam int AMP_BITS   = 16;
    localparam int NUM_HARM   = 3;
    localparam int NUM_STAGES = 5;

    // Sine lookup geometry: 64 table steps per quarter turn, 8 fraction bits.
    localparam int FRAC_BITS = 8;
    localparam int IDX_BITS  = 7;
    localparam int SIN_BITS  = 15;
    localparam int DIFF_BITS = 10;
    localparam int SIN_SHIFT = 15;
    localparam int TERM_BITS = 2 * AMP_BITS - SIN_SHIFT;
    localparam int SUM_BITS  = TERM_BITS + 2;
    localparam logic [IDX_BITS-1:0] QTR_TOP  = 7'd64;
    localparam logic [14:0]         QTR_SPAN = 15'h4000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_AMP_H1   = 3'd0,
        CFG_AMP_H2   = 3'd1,
        CFG_AMP_H3   = 3'd2,
        CFG_PHASE_H1 = 3'd3,
        CFG_PHASE_H2 = 3'd4,
        CFG_PHASE_H3 = 3'd5
    } t_cfg_idx;

    typedef logic [ANGLE_BITS-1:0] t_angle;
    typedef logic [PHASE_BITS-1:0] t_phase;

    // Register file contents handed to the datapath.
    typedef struct packed {
        logic [NUM_HARM-1:0][AMP_BITS-1:0]   amp;
        logic [NUM_HARM-1:0][PHASE_BITS-1:0] phase;
    } t_cfg;

    // Load enables for the stages that live inside each harmonic lane.
    typedef struct packed {
        logic en_fold;
        logic en_interp;
        logic en_mult;
    } t_lane_en;

    // Quarter-wave sine, entry i = round(sin(i/64 * pi/2) * 32767).
    localparam logic [SIN_BITS-1:0] QSIN [0:64] = '{
        15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
        15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
        15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
        15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
        15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
        15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
        15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
        15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
        15'd32767
    };

    // Table read; any index past the top returns the top entry, so the
    // upper neighbor of the last entry gives a zero slope.
    function automatic logic [SIN_BITS-1:0] quarter_sine(input logic [IDX_BITS-1:0] idx);
        logic [SIN_BITS-1:0] v;
        if (idx >= QTR_TOP) begin
            v = QSIN[64];
        end else begin
            v = QSIN[idx];
        end
        return v;
    endfunction

endpackage

[sv/hac_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file: three amplitudes and three phases.
// Depends on hac_pkg for the register indexes and the t_cfg struct.
module hac_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [2:0]                   i_wr_index,
    input  logic [hac_pkg::AMP_BITS-1:0] i_wr_data,
    output hac_pkg::t_cfg                o_cfg
);

    hac_pkg::t_cfg r_cfg;
    hac_pkg::t_cfg n_cfg;

    // Decode the write; unknown indexes leave every register alone.
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                hac_pkg::CFG_AMP_H1:   n_cfg.amp[0]   = i_wr_data;
                hac_pkg::CFG_AMP_H2:   n_cfg.amp[1]   = i_wr_data;
                hac_pkg::CFG_AMP_H3:   n_cfg.amp[2]   = i_wr_data;
                hac_pkg::CFG_PHASE_H1: n_cfg.phase[0] = i_wr_data;
                hac_pkg::CFG_PHASE_H2: n_cfg.phase[1] = i_wr_data;
                hac_pkg::CFG_PHASE_H3: n_cfg.phase[2] = i_wr_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/hac_lane.sv]
`timescale 1ns / 1ps
// One harmonic lane: quadrant fold and table read, interpolation, amplitude multiply.
// Depends on hac_pkg for the sine table, widths and the t_lane_en struct.
module hac_lane (
    input  logic                           i_clk,
    input  hac_pkg::t_lane_en              i_en,
    input  hac_pkg::t_phase                i_arg,
    input  logic [hac_pkg::AMP_BITS-1:0]   i_amp,
    output logic [2*hac_pkg::AMP_BITS-1:0] o_prod
);

    logic [14:0]                    w_x;
    logic [hac_pkg::IDX_BITS-1:0]   w_idx;
    logic [hac_pkg::SIN_BITS-1:0]   w_hi;
    logic [hac_pkg::SIN_BITS-1:0]   n_lo;
    logic [hac_pkg::DIFF_BITS-1:0]  n_diff;
    logic [hac_pkg::SIN_BITS-1:0]   r_lo;
    logic [hac_pkg::DIFF_BITS-1:0]  r_diff;
    logic [hac_pkg::FRAC_BITS-1:0]  r_frac;
    logic                           r_neg;
    logic [hac_pkg::DIFF_BITS+hac_pkg::FRAC_BITS-1:0] w_step;
    logic [hac_pkg::SIN_BITS:0]     w_mag;
    logic signed [hac_pkg::AMP_BITS-1:0]   n_sv;
    logic signed [hac_pkg::AMP_BITS-1:0]   r_sv;
    logic signed [2*hac_pkg::AMP_BITS-1:0] n_prod;
    logic signed [2*hac_pkg::AMP_BITS-1:0] r_prod;

    // Fold the angle into the first quadrant and read both neighbors.
    always_comb begin
        w_x = {1'b0, i_arg[13:0]};
        if (i_arg[14]) begin
            w_x = hac_pkg::QTR_SPAN - w_x;
        end
        w_idx  = w_x[14:hac_pkg::FRAC_BITS];
        n_lo   = hac_pkg::quarter_sine(w_idx);
        w_hi   = hac_pkg::quarter_sine(w_idx + 7'd1);
        n_diff = hac_pkg::DIFF_BITS'(w_hi - n_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_fold) begin
            r_lo   <= n_lo;
            r_diff <= n_diff;
            r_frac <= w_x[hac_pkg::FRAC_BITS-1:0];
            r_neg  <= i_arg[15];
        end
    end

    // Linear interpolation; the slope is never negative, so the shift is a floor.
    always_comb begin
        w_step = hac_pkg::DIFF_BITS'(r_diff) * hac_pkg::FRAC_BITS'(r_frac);
        w_mag  = {1'b0, r_lo} + {6'd0, w_step[hac_pkg::DIFF_BITS+hac_pkg::FRAC_BITS-1:
                                              hac_pkg::FRAC_BITS]};
        n_sv   = r_neg ? -$signed({1'b0, w_mag[hac_pkg::SIN_BITS-1:0]})
                       :  $signed({1'b0, w_mag[hac_pkg::SIN_BITS-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_interp) begin
            r_sv <= n_sv;
        end
    end

    // Signed amplitude times signed Q15 sine.
    assign n_prod = $signed(i_amp) * r_sv;

    always_ff @(posedge i_clk) begin
        if (i_en.en_mult) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[sv/harmonic_angle_compensator_top.sv]
`timescale 1ns / 1ps
// Top level of the harmonic angle compensator: handshakes, argument stage, lanes, final sum.
// Depends on hac_pkg, hac_cfg and hac_lane.
//
//   Channel   Signals                                        Direction
//   input     i_valid, o_ready, i_raw_angle                  into block
//   result    o_valid, i_ready, o_corrected_angle            out of block
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  into block
//
// Five register stages: harmonic argument, fold and table read, interpolation,
// amplitude multiply, sum and output register, passed through in that order.
// One item is taken in every cycle unless the output stalls, since each stage holds
// one item and passes it on. Reset clears only the stage valid bits, not the data
// registers; no clearing pass is needed.
// A stall at the output backs up through the stages; bubbles are squeezed out.
module harmonic_angle_compensator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  hac_pkg::t_angle               i_raw_angle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output hac_pkg::t_angle               o_corrected_angle,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [hac_pkg::AMP_BITS-1:0]  i_cfg_data
);

    localparam int NS = hac_pkg::NUM_STAGES;

    hac_pkg::t_cfg                               w_cfg;
    logic [NS-1:0]                               r_vld;
    logic [NS-1:0]                               w_en;
    hac_pkg::t_lane_en                           w_lane_en;
    hac_pkg::t_angle                             r_raw [0:NS-2];
    hac_pkg::t_angle                             w_mult [0:hac_pkg::NUM_HARM-1];
    hac_pkg::t_phase                             n_arg [0:hac_pkg::NUM_HARM-1];
    hac_pkg::t_phase                             r_arg [0:hac_pkg::NUM_HARM-1];
    logic [2*hac_pkg::AMP_BITS-1:0]              w_prod [0:hac_pkg::NUM_HARM-1];
    logic signed [hac_pkg::SUM_BITS-1:0]         w_sum;
    hac_pkg::t_angle                             n_out;
    hac_pkg::t_angle                             r_out;

    // Configuration registers; always ready.
    assign o_cfg_ready = 1'b1;

    hac_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_vld[NS-1];
    assign w_lane_en = '{en_fold: w_en[1], en_interp: w_en[2], en_mult: w_en[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Harmonic arguments: k times the angle, top 16 bits, plus the phase.
    assign w_mult[0] = i_raw_angle;
    assign w_mult[1] = {i_raw_angle[hac_pkg::ANGLE_BITS-2:0], 1'b0};
    assign w_mult[2] = i_raw_angle + {i_raw_angle[hac_pkg::ANGLE_BITS-2:0], 1'b0};

    always_comb begin
        for (int k = 0; k < hac_pkg::NUM_HARM; k++) begin
            n_arg[k] = w_mult[k][hac_pkg::ANGLE_BITS-1 -: hac_pkg::PHASE_BITS]
                     + w_cfg.phase[k];
        end
    end

    // Argument registers and the raw angle that travels with the item.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int k = 0; k < hac_pkg::NUM_HARM; k++) begin
                r_arg[k] <= n_arg[k];
            end
            r_raw[0] <= i_raw_angle;
        end
        for (int s = 1; s < NS - 1; s++) begin
            if (w_en[s]) begin
                r_raw[s] <= r_raw[s-1];
            end
        end
    end

    // One lane per harmonic.
    for (genvar g = 0; g < hac_pkg::NUM_HARM; g++) begin : g_lane
        hac_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_lane_en),
            .i_arg  (r_arg[g]),
            .i_amp  (w_cfg.amp[g]),
            .o_prod (w_prod[g])
        );
    end

    // Floor shift of each product, sum of the terms, subtract and wrap.
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < hac_pkg::NUM_HARM; k++) begin
            w_sum = w_sum + hac_pkg::SUM_BITS'($signed(
                w_prod[k][2*hac_pkg::AMP_BITS-1:hac_pkg::SIN_SHIFT]));
        end
        n_out = r_raw[NS-2] - hac_pkg::ANGLE_BITS'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_corrected_angle = r_out;

    // A full pipeline with a stalled output must not take a new item.
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_ready) |-> !o_ready)
        else $error("input taken while the pipeline is full and stalled");

    // An item taken with none leaving adds exactly one valid stage.
    a_count_up : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !(o_valid && i_ready))
        |=> $countones(r_vld) == $past($countones(r_vld)) + 1)
        else $error("accepted item lost in the pipeline");

    // An item leaving with none taken removes exactly one valid stage.
    a_count_down : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_valid && o_ready) && o_valid && i_ready)
        |=> $countones(r_vld) == $past($countones(r_vld)) - 1)
        else $error("delivered item repeated or invented");

endmodule

[sim/harmonic_angle_compensator_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for harmonic_angle_compensator_top: directed table, then random angles.
// Depends on hac_pkg and the RTL; expected angles come from a local predictor or known values.
module harmonic_angle_compensator_top_tb;

    localparam int   HOLD_CYCLES   = 64;
    localparam int   WATCHDOG_MAX  = 5000;
    localparam int   ITEMS_PER_SET = 167;
    localparam int   SETS_PER_PASS = 4;
    localparam int   N_DIRECTED    = 20;
    localparam logic [14:0] QUARTER_TURN = 15'h4000;
    localparam logic [15:0] AMP_MAX      = 16'h7FFF;
    localparam logic [15:0] AMP_MIN      = 16'h8000;

    // Register indexes past the last register; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Quarter-wave sine, entry i = round(sin(i/64 * pi/2) * 32767).
    localparam int SINE_QTR [0:64] = '{
        0, 804, 1608, 2410, 3212, 4011, 4808, 5602,
        6393, 7179, 7962, 8739, 9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
        23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    typedef struct packed {
        logic [15:0] amp1;
        logic [15:0] amp2;
        logic [15:0] amp3;
        logic [15:0] ph1;
        logic [15:0] ph2;
        logic [15:0] ph3;
    } t_comp_setting;

    typedef struct packed {
        logic [1:0]      setting;
        hac_pkg::t_angle angle;
        logic            known;
        hac_pkg::t_angle known_val;
    } t_vector;

    typedef struct packed {
        hac_pkg::t_angle raw;
        hac_pkg::t_angle want;
    } t_pending;

    // Directed register settings; entry 0 is the state after reset and is never written.
    localparam t_comp_setting DIRECTED_SETTINGS [0:3] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{AMP_MAX,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{AMP_MIN,  AMP_MIN,  AMP_MIN,  16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{AMP_MAX,  AMP_MAX,  AMP_MAX,  16'h4000, 16'h8000, 16'hC000}
    };

    // Directed angles. Known values: zero amplitudes pass the angle through; with only
    // amp_h1 at full scale, the quarter-turn edges read the top table entry directly,
    // and the negative edge term rounds toward minus infinity.
    localparam t_vector DIRECTED [0:N_DIRECTED-1] = '{
        '{2'd0, 21'h000000, 1'b1, 21'h000000},
        '{2'd0, 21'h1FFFFF, 1'b1, 21'h1FFFFF},
        '{2'd0, 21'h155555, 1'b1, 21'h155555},
        '{2'd0, 21'h0AAAAA, 1'b1, 21'h0AAAAA},
        '{2'd0, 21'h080000, 1'b1, 21'h080000},
        '{2'd1, 21'h080000, 1'b1, 21'h078002},
        '{2'd1, 21'h180000, 1'b1, 21'h187FFF},
        '{2'd1, 21'h000000, 1'b1, 21'h000000},
        '{2'd1, 21'h100000, 1'b1, 21'h100000},
        '{2'd1, 21'h000123, 1'b0, 21'h000000},
        '{2'd2, 21'h000000, 1'b0, 21'h000000},
        '{2'd2, 21'h1FFFFF, 1'b0, 21'h000000},
        '{2'd2, 21'h0AAAAA, 1'b0, 21'h000000},
        '{2'd2, 21'h155555, 1'b0, 21'h000000},
        '{2'd2, 21'h07FFE0, 1'b0, 21'h000000},
        '{2'd3, 21'h000000, 1'b0, 21'h000000},
        '{2'd3, 21'h1FFFFF, 1'b0, 21'h000000},
        '{2'd3, 21'h0FFFFF, 1'b0, 21'h000000},
        '{2'd3, 21'h012345, 1'b0, 21'h000000},
        '{2'd3, 21'h1C0000, 1'b0, 21'h000000}
    };

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_valid     = 1'b0;
    logic            o_ready;
    hac_pkg::t_angle i_raw_angle = '0;
    logic            o_valid;
    logic            i_ready     = 1'b0;
    hac_pkg::t_angle o_corrected_angle;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [2:0]      i_cfg_index = '0;
    logic [15:0]     i_cfg_data  = '0;

    // Register shadow that the predictor works from.
    t_comp_setting comp_regs = '0;

    t_pending pending_angles [$];
    int       mismatch_count = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;
    int       hold_left      = 0;
    logic     hold_req       = 1'b0;
    int       quiet_cycles   = 0;

    harmonic_angle_compensator_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_angle       (i_raw_angle),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_corrected_angle (o_corrected_angle),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Q15 sine of a 16-bit binary angle with quadrant mirroring and linear interpolation.
    function automatic int sine_q15_of(input logic [15:0] a);
        logic [14:0] x;
        int          idx;
        int          frac;
        int          v;
        x = {1'b0, a[13:0]};
        if (a[14]) begin
            x = QUARTER_TURN - x;
        end
        idx  = int'(x[14:8]);
        frac = int'(x[7:0]);
        if (idx >= 64) begin
            v = SINE_QTR[64];
        end else begin
            v = SINE_QTR[idx] + (((SINE_QTR[idx + 1] - SINE_QTR[idx]) * frac) >>> 8);
        end
        if (a[15]) begin
            v = -v;
        end
        return v;
    endfunction

    // One harmonic: k times the angle, top 16 bits plus phase, scaled and floored.
    function automatic longint harmonic_term_of(input hac_pkg::t_angle u, input int k,
                                                input logic [15:0] amp, input logic [15:0] ph);
        logic [63:0] karg;
        logic [15:0] a16;
        longint      prod;
        karg = 64'(k) * 64'(u);
        a16  = karg[hac_pkg::ANGLE_BITS-1 -: 16] + ph;
        prod = longint'($signed(amp)) * longint'(sine_q15_of(a16));
        return prod >>> 15;
    endfunction

    function automatic hac_pkg::t_angle corrected_angle_of(input hac_pkg::t_angle u,
                                                           input t_comp_setting s);
        longint      delta;
        logic [63:0] diff;
        delta = harmonic_term_of(u, 1, s.amp1, s.ph1)
              + harmonic_term_of(u, 2, s.amp2, s.ph2)
              + harmonic_term_of(u, 3, s.amp3, s.ph3);
        diff = 64'(u) - 64'(delta);
        return diff[hac_pkg::ANGLE_BITS-1:0];
    endfunction

    // Amplitudes lean toward full scale and zero; phases toward the quadrant edges.
    function automatic logic [15:0] pick_amp();
        logic [15:0] v;
        case ($urandom_range(4))
            0: v = AMP_MAX;
            1: v = AMP_MIN;
            2: v = 16'h0000;
            3: v = 16'($signed($urandom_range(200)) - 100);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_phase();
        logic [15:0] v;
        if ($urandom_range(1) == 0) begin
            v = 16'($urandom_range(3)) << 14;
            if ($urandom_range(3) == 0) begin
                v = v - 16'd1;
            end
        end else begin
            v = 16'($urandom);
        end
        return v;
    endfunction

    // Mostly uniform angles; the rest land the first harmonic on or next to a quadrant edge.
    function automatic hac_pkg::t_angle pick_angle();
        logic [15:0]     target;
        hac_pkg::t_angle a;
        if ($urandom_range(3) != 0) begin
            a = hac_pkg::t_angle'($urandom);
        end else begin
            target = (16'($urandom_range(3)) << 14) - comp_regs.ph1;
            a = {target, 5'($urandom_range(31))};
        end
        return a;
    endfunction

    // Configuration write; called at a falling edge, returns at a falling edge.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            hac_pkg::CFG_AMP_H1:   comp_regs.amp1 = data;
            hac_pkg::CFG_AMP_H2:   comp_regs.amp2 = data;
            hac_pkg::CFG_AMP_H3:   comp_regs.amp3 = data;
            hac_pkg::CFG_PHASE_H1: comp_regs.ph1  = data;
            hac_pkg::CFG_PHASE_H2: comp_regs.ph2  = data;
            hac_pkg::CFG_PHASE_H3: comp_regs.ph3  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits until every item sent so far has come back; the input stays quiet meanwhile.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_angles.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic apply_setting(input t_comp_setting s);
        wait_drained();
        write_reg(hac_pkg::CFG_AMP_H1, s.amp1);
        write_reg(hac_pkg::CFG_AMP_H2, s.amp2);
        write_reg(hac_pkg::CFG_AMP_H3, s.amp3);
        write_reg(hac_pkg::CFG_PHASE_H1, s.ph1);
        write_reg(hac_pkg::CFG_PHASE_H2, s.ph2);
        write_reg(hac_pkg::CFG_PHASE_H3, s.ph3);
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
    endtask

    // Offers one angle and records its expected result once the block takes it.
    // Valid is left high on return so back-to-back items keep it up.
    task automatic send_angle(input hac_pkg::t_angle a, input logic known,
                              input hac_pkg::t_angle known_val);
        t_pending p;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_raw_angle = a;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        p.raw  = a;
        p.want = known ? known_val : corrected_angle_of(a, comp_regs);
        pending_angles.push_back(p);
        @(negedge i_clk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_ready   = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each returned angle with the oldest expectation.
    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, o_corrected_angle);
                mismatch_count = mismatch_count + 1;
            end else begin
                p = pending_angles.pop_front();
                if (o_corrected_angle !== p.want) begin
                    $display("%0t: corrected_angle for raw %h: expected %h, actual %h",
                             $time, p.raw, p.want, o_corrected_angle);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on any channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int cur_setting;
        int pass_idx;
        int set_idx;
        int item_idx;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, no idling on either side.
        cur_setting = 0;
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (int'(DIRECTED[r].setting) != cur_setting) begin
                cur_setting = int'(DIRECTED[r].setting);
                apply_setting(DIRECTED_SETTINGS[cur_setting]);
            end
            send_angle(DIRECTED[r].angle, DIRECTED[r].known, DIRECTED[r].known_val);
        end

        // Random angles in three passes: slow result side, slow input side, no idling.
        for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
            case (pass_idx)
                0: begin send_idle_pct = 19; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (set_idx = 0; set_idx < SETS_PER_PASS; set_idx++) begin
                apply_setting('{pick_amp(), pick_amp(), pick_amp(),
                                pick_phase(), pick_phase(), pick_phase()});
                for (item_idx = 0; item_idx < ITEMS_PER_SET; item_idx++) begin
                    // With both sides flat out, stall the result side long enough to back
                    // the pipeline up into the input.
                    if (pass_idx == 2 && set_idx == 1 && item_idx == 20) begin
                        hold_req = 1'b1;
                    end
                    send_angle(pick_angle(), 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (hac_pkg::NUM_STAGES + 3) @(negedge i_clk);

        if (mismatch_count == 0 && pending_angles.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
